/* rtl/core/lzwe_pkg.sv */
// ----------------------------------------------------------------------------
// lzwe_pkg
// Types and constants shared by the LZW encoder modules.
// ----------------------------------------------------------------------------
package lzwe_pkg;

  localparam int unsigned SINGLE_CODES   = 256;
  localparam int unsigned CODE_SPACE     = 4096;
  localparam logic [1:0]  REG_DICT_LIMIT = 2'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [11:0] code;
    logic        last_code;
  } out_word_t;

  typedef struct packed {
    logic        found;
    logic [11:0] code;
  } chain_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_CMP
  } lzwe_state_t;

endpackage

/* rtl/core/lzwe_ram.sv */
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lzwe_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lzwe_cell.sv */
// ----------------------------------------------------------------------------
// lzwe_cell
// One dictionary cell: a bank of entries with a comparator, chained to its
// neighbor so that a match found earlier in the row passes through.
// ----------------------------------------------------------------------------
module lzwe_cell import lzwe_pkg::*; #(
  parameter int CELLS  = 8,
  parameter int LANE   = 0,
  parameter int ROWS   = 64
) (
  input  logic                    clk,
  input  logic [$clog2(ROWS)-1:0] rd_row,
  input  logic [19:0]             key,
  input  logic [12:0]             next_free,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] wr_row,
  input  logic [19:0]             wr_pair,
  input  chain_t                  chain_in,
  output chain_t                  chain_out
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELL_W = $clog2(CELLS);

  logic [19:0]      pair;
  logic [ROW_W-1:0] cmp_row;
  logic [12:0]      my_code;
  logic             match;

  lzwe_ram #(.WIDTH(20), .DEPTH(ROWS)) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr (wr_row),
    .wdata (wr_pair),
    .raddr (rd_row),
    .rdata (pair)
  );

  always_ff @(posedge clk) begin
    cmp_row <= rd_row;
  end

  assign my_code = 13'({cmp_row, CELL_W'(LANE)});
  assign match   = (my_code < next_free) && (pair == key);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && match) begin
      chain_out.found = 1'b1;
      chain_out.code  = my_code[11:0];
    end
  end

endmodule

/* rtl/core/lzw_encoder_unit.sv */
// ----------------------------------------------------------------------------
// lzw_encoder_unit
// LZW encoder with 12-bit codes and a dictionary searched by a row of cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// in        input      data_byte, end_of_message
// out       output     code, last_code
// apb       config     dict_limit at address 0
//
// A first byte passes from S_IDLE through S_START back to S_IDLE. A later
// byte may also scan rows of CELLS entries, up to (next free code - 256) /
// CELLS rows rounded up, each with an S_READ bank read and an S_CMP compare.
// Reset clears the dictionary by resetting the fill count; no clearing pass.
// Results queue in a four-word buffer, so an out stall holds the input only
// once more than two words wait.
// ----------------------------------------------------------------------------
module lzw_encoder_unit import lzwe_pkg::*; #(
  parameter int DICT_DEPTH = 4096,
  parameter int CELLS      = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EFF_DEPTH = (DICT_DEPTH < CODE_SPACE) ? DICT_DEPTH : CODE_SPACE;
  localparam int ROWS      = EFF_DEPTH / CELLS;
  localparam int ADDR_W    = $clog2(EFF_DEPTH);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam logic [ROW_W-1:0] START_ROW = ROW_W'(SINGLE_CODES / CELLS);

  lzwe_state_t      state, state_next;
  logic [12:0]      dict_limit;
  logic [11:0]      prefix, prefix_next;
  logic             prefix_valid, prefix_valid_next;
  logic [12:0]      next_free, next_free_next;
  logic [ROW_W-1:0] row, row_next;
  in_word_t         cur;
  logic [12:0]      last_code_idx;
  logic [ROW_W-1:0] last_row;

  logic             decide, hit;
  logic [11:0]      newp;
  logic             wr_en;
  logic [1:0]       push_n;
  out_word_t        w0, w1;

  out_word_t        fifo [4];
  logic [1:0]       wp, rp;
  logic [2:0]       count;
  logic             pop;

  chain_t           chain [CELLS+1];

  assign pready = 1'b1;
  assign prdata = {19'd0, dict_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      dict_limit <= 13'(CODE_SPACE);
    end else if (psel && penable && pwrite && paddr == REG_DICT_LIMIT[0:0]) begin
      dict_limit <= pwdata[12:0];
    end
  end

  assign last_code_idx = next_free - 13'd1;
  assign last_row      = last_code_idx[ADDR_W-1:CELL_W];

  assign chain[0] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    lzwe_cell #(.CELLS(CELLS), .LANE(i), .ROWS(ROWS)) u_cell (
      .clk       (clk),
      .rd_row    (row),
      .key       ({prefix, cur.data_byte}),
      .next_free (next_free),
      .we        (wr_en && next_free[CELL_W-1:0] == CELL_W'(i)),
      .wr_row    (next_free[ADDR_W-1:CELL_W]),
      .wr_pair   ({prefix, cur.data_byte}),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  assign in_stall = !(state == S_IDLE && count <= 3'd2);

  always_comb begin
    state_next        = state;
    row_next          = row;
    decide            = 1'b0;
    hit               = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (prefix_valid && next_free > 13'(SINGLE_CODES)) begin
          row_next   = START_ROW;
          state_next = S_READ;
        end else begin
          decide     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (chain[CELLS].found) begin
          hit        = 1'b1;
          decide     = 1'b1;
          state_next = S_IDLE;
        end else if (row == last_row) begin
          decide     = 1'b1;
          state_next = S_IDLE;
        end else begin
          row_next   = row + ROW_W'(1);
          state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    prefix_next       = prefix;
    prefix_valid_next = prefix_valid;
    next_free_next    = next_free;
    wr_en             = 1'b0;
    push_n            = 2'd0;
    newp              = prefix;
    w0                = '0;
    w1                = '0;
    if (decide) begin
      if (!prefix_valid) begin
        newp = {4'd0, cur.data_byte};
      end else if (hit) begin
        newp = chain[CELLS].code;
      end else begin
        w0     = '{code: prefix, last_code: 1'b0};
        push_n = 2'd1;
        newp   = {4'd0, cur.data_byte};
        if (next_free < dict_limit && next_free < 13'(EFF_DEPTH)) begin
          wr_en          = 1'b1;
          next_free_next = next_free + 13'd1;
        end
      end
      prefix_next       = newp;
      prefix_valid_next = 1'b1;
      if (cur.end_of_message) begin
        if (push_n == 2'd0) begin
          w0 = '{code: newp, last_code: 1'b1};
        end else begin
          w1 = '{code: newp, last_code: 1'b1};
        end
        push_n            = push_n + 2'd1;
        prefix_next       = 12'd0;
        prefix_valid_next = 1'b0;
        next_free_next    = 13'(SINGLE_CODES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prefix       <= 12'd0;
      prefix_valid <= 1'b0;
      next_free    <= 13'(SINGLE_CODES);
    end else begin
      state        <= state_next;
      prefix       <= prefix_next;
      prefix_valid <= prefix_valid_next;
      next_free    <= next_free_next;
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
    if (in_valid && !in_stall) begin
      cur <= in_word;
    end
  end

  assign pop       = out_valid && !out_stall;
  assign out_valid = count != 3'd0;
  assign out_word  = fifo[rp];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wp] <= w0;
    end
    if (push_n == 2'd2) begin
      fifo[wp + 2'd1] <= w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 2'd0;
      rp    <= 2'd0;
      count <= 3'd0;
    end else begin
      wp    <= wp + push_n;
      rp    <= rp + 2'(pop);
      count <= count + 3'(push_n) - 3'(pop);
    end
  end

endmodule

/* rtl/core/lzwe_checker.sv */
// ----------------------------------------------------------------------------
// lzwe_assert
// Port-level checks on the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzwe_assert import lzwe_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word,
  input logic      pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind lzw_encoder_unit lzwe_assert u_lzwe_assert (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word),
  .pready    (pready)
);

/* dv/lzwe_checker.sv */
// ----------------------------------------------------------------------------
// lzwe_checker
// Watches the byte, code and APB channels of the LZW encoder. It keeps its
// own dictionary and prefix, predicts the codes of every accepted byte word
// and compares each accepted code word with the oldest prediction.
// ----------------------------------------------------------------------------
module lzwe_checker import lzwe_pkg::*; #(
  parameter int DICT_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending,
  output int          codes_seen,
  output int          full_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [12:0] limit_reg;
  logic [11:0] cur_prefix;
  logic        have_prefix;
  logic [12:0] free_code;
  logic [19:0] pair_mem [DICT_DEPTH];
  logic        pair_ok  [DICT_DEPTH];
  out_word_t   code_q[$];

  function automatic int unsigned cap_limit();
    int unsigned lim;
    lim = limit_reg;
    if (lim > CODE_SPACE) lim = CODE_SPACE;
    if (lim > DICT_DEPTH) lim = DICT_DEPTH;
    return lim;
  endfunction

  task automatic encode_byte(input in_word_t w);
    logic [19:0] key;
    int          hit;
    if (!have_prefix) begin
      cur_prefix  = {4'd0, w.data_byte};
      have_prefix = 1'b1;
    end else begin
      key = {cur_prefix, w.data_byte};
      hit = -1;
      for (int i = SINGLE_CODES; i < free_code && i < DICT_DEPTH; i++) begin
        if (pair_ok[i] && pair_mem[i] == key) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        cur_prefix = hit[11:0];
      end else begin
        code_q.push_back('{code: cur_prefix, last_code: 1'b0});
        if (free_code < cap_limit()) begin
          pair_mem[free_code] = key;
          pair_ok[free_code]  = 1'b1;
          free_code++;
        end else begin
          full_hits++;
        end
        cur_prefix = {4'd0, w.data_byte};
      end
    end
    if (w.end_of_message) begin
      code_q.push_back('{code: cur_prefix, last_code: 1'b1});
      cur_prefix  = '0;
      have_prefix = 1'b0;
      free_code   = 13'(SINGLE_CODES);
      for (int i = 0; i < DICT_DEPTH; i++) pair_ok[i] = 1'b0;
    end
  endtask

  initial begin
    fails      = 0;
    pending    = 0;
    codes_seen = 0;
    full_hits  = 0;
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      limit_reg   = 13'(CODE_SPACE);
      cur_prefix  = '0;
      have_prefix = 1'b0;
      free_code   = 13'(SINGLE_CODES);
      for (int i = 0; i < DICT_DEPTH; i++) pair_ok[i] = 1'b0;
      code_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_DICT_LIMIT[0:0])
        limit_reg = pwdata[12:0];
      if (in_valid && !in_stall)
        encode_byte(in_word);
      if (out_valid && !out_stall) begin
        codes_seen++;
        if (code_q.size() == 0) begin
          $display("%0t: unexpected code word, expected none, actual code=%0d last=%0b",
                   $time, out_word.code, out_word.last_code);
          fails++;
        end else begin
          want = code_q.pop_front();
          if (want.code !== out_word.code) begin
            $display("%0t: code mismatch, expected %0d, actual %0d",
                     $time, want.code, out_word.code);
            fails++;
          end
          if (want.last_code !== out_word.last_code) begin
            $display("%0t: last_code mismatch, expected %0b, actual %0b",
                     $time, want.last_code, out_word.last_code);
            fails++;
          end
        end
      end
    end
    pending = code_q.size();
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives byte messages into the LZW encoder with random gaps and code-side
// stalls, rewrites the dictionary limit while the block is idle, and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb import lzwe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE   = 1000;
  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fails, pending, codes_seen, full_hits;
  int bytes_sent, messages, limit_writes, idle_count;
  int stall_left;
  bit stall_on;

  lzw_encoder_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lzwe_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fails, .pending, .codes_seen, .full_hits
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_on   <= ($urandom_range(0, 2) == 0);
      stall_left <= gap_len() + 1;
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      out_stall  <= stall_on;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: b, end_of_message: eom};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (eom) messages++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DICT_LIMIT[0:0];
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    limit_writes++;
  endtask

  task automatic send_message(input int len, input bit noisy, input bit close);
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      if (noisy)
        send_byte(8'($urandom_range(0, 255)), close && i == len - 1);
      else
        send_byte(base + 8'($urandom_range(0, 3)), close && i == len - 1);
    end
  endtask

  initial begin
    int len, r;
    in_valid     = 1'b0;
    in_word      = '0;
    out_stall    = 1'b0;
    stall_left   = 0;
    stall_on     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_count   = 0;
    bytes_sent   = 0;
    messages     = 0;
    limit_writes = 0;
    rst          = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b1);
    write_limit(32'd257);
    for (int i = 0; i < 8; i++) send_byte(8'h41 + 8'(i % 2), i == 7);
    write_limit(32'd0);
    for (int i = 0; i < 4; i++) send_byte(8'h5a, i == 3);
    write_limit(32'hFFFF_FFFF);
    send_message(6, 1'b0, 1'b0);
    write_limit(32'd258);
    send_message(6, 1'b0, 1'b1);
    write_limit(32'd4096);

    while (bytes_sent < 1450) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        r = $urandom_range(0, 5);
        case (r)
          0: write_limit(32'd257);
          1: write_limit(32'd4096);
          2: write_limit(32'($urandom_range(0, 256)));
          3: write_limit(32'($urandom_range(4097, 8191)) | 32'($urandom) << 13);
          default: write_limit(32'($urandom_range(257, 300)));
        endcase
      end else if (r < 12) begin
        settle();
      end
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 30);
      else if (r < 98) len = $urandom_range(31, 120);
      else len = $urandom_range(200, 400);
      send_message(len, $urandom_range(0, 9) == 0, $urandom_range(0, 19) != 0);
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    settle();

    $display("Sent %0d bytes in %0d messages with %0d limit writes.",
             bytes_sent, messages, limit_writes);
    $display("Checked %0d codes, %0d of them with the dictionary full.",
             codes_seen, full_hits);
    if (fails == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/core/lzwe_pkg.sv
rtl/core/lzwe_ram.sv
rtl/core/lzwe_cell.sv
rtl/core/lzw_encoder_unit.sv
rtl/core/lzwe_checker.sv
dv/lzwe_checker.sv
dv/tb.sv
